[src/triaxial_sample_scale_and_average_defines.svh]
// Assertion macros shared by the block's modules.
`ifndef TRIAXIAL_SAMPLE_SCALE_AND_AVERAGE_DEFINES_SVH
`define TRIAXIAL_SAMPLE_SCALE_AND_AVERAGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/tssa_pkg.sv]
package tssa_pkg;

	localparam int NUM_AXES      = 3;
	localparam int RAW_W         = 16;
	localparam int LOW_W         = 12;
	localparam int CONV_W        = 15;
	localparam int MEAN_W        = 15;
	localparam int AVG_COUNT_DEF = 10;
	localparam int QUEUE_DEPTH   = 4;
	localparam int RECIP_SHIFT   = 31;
	localparam int RECIP_W       = 32;

	localparam logic [RAW_W-LOW_W-1:0] NEG_NIBBLE = 4'hF;

	typedef logic signed [CONV_W-1:0] conv_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][CONV_W-1:0] conv;
		logic                            last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// A word whose top nibble is all ones is treated as a negative reading.
	function automatic conv_t convert_axis(input logic [RAW_W-1:0] w);
		logic [LOW_W-1:0]  low;
		logic [CONV_W-1:0] mag;
		logic              neg;
		neg = (w[RAW_W-1:LOW_W] == NEG_NIBBLE);
		if (neg) begin
			low = {LOW_W{1'b0}} - w[LOW_W-1:0];
		end else begin
			low = w[LOW_W-1:0];
		end
		mag = {1'b0, low, 2'b00};
		if (neg) begin
			return conv_t'({CONV_W{1'b0}} - mag);
		end
		return conv_t'(mag);
	endfunction

endpackage

[src/tssa_front.sv]
module tssa_front #(
	parameter int AVG_COUNT = tssa_pkg::AVG_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tssa_pkg::RAW_W-1:0]   x_raw,
	input  logic [tssa_pkg::RAW_W-1:0]   y_raw,
	input  logic [tssa_pkg::RAW_W-1:0]   z_raw,
	input  tssa_pkg::q_status_t          q_status,
	output logic                         push,
	output tssa_pkg::item_t              push_item
);
	import tssa_pkg::*;

	localparam int CNT_W = $clog2(AVG_COUNT + 1);

	logic [CNT_W-1:0] count_q;
	logic             closes;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;
	assign closes   = (count_q == CNT_W'(AVG_COUNT - 1));

	always_comb begin
		push_item.conv[0] = convert_axis(x_raw);
		push_item.conv[1] = convert_axis(y_raw);
		push_item.conv[2] = convert_axis(z_raw);
		push_item.last    = closes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (closes) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

[src/tssa_queue.sv]
`include "triaxial_sample_scale_and_average_defines.svh"

module tssa_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tssa_pkg::item_t     push_item,
	input  logic                pop,
	output tssa_pkg::item_t     head_item,
	output tssa_pkg::q_status_t q_status
);
	import tssa_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_item      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TSSA_ASSERT_SAME(a_no_overflow, clk, arst_n, push, !q_status.full, "queue written when full")
	`TSSA_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, !q_status.empty, "queue read when empty")
	`TSSA_ASSERT_NEXT(a_fill, clk, arst_n, push && !pop, !q_status.empty, "queue lost a word")

endmodule

[src/tssa_back.sv]
`include "triaxial_sample_scale_and_average_defines.svh"

module tssa_back #(
	parameter int AVG_COUNT = tssa_pkg::AVG_COUNT_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  tssa_pkg::q_status_t                              q_status,
	input  tssa_pkg::item_t                                  head_item,
	output logic                                             pop,
	output logic                                             out_valid,
	input  logic                                             out_stall,
	output logic [tssa_pkg::NUM_AXES-1:0][tssa_pkg::MEAN_W-1:0] means
);
	import tssa_pkg::*;

	localparam int SUM_W  = CONV_W + $clog2(AVG_COUNT) + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int D_W    = $clog2(AVG_COUNT + 1);
	localparam int QD_W   = MAG_W + D_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / AVG_COUNT);

	logic signed [SUM_W-1:0] sums_q  [NUM_AXES];
	logic signed [SUM_W-1:0] next_sum [NUM_AXES];
	logic signed [SUM_W-1:0] sum_s1  [NUM_AXES];
	logic [MAG_W-1:0]        mag_s2  [NUM_AXES];
	logic                    neg_s2  [NUM_AXES];
	logic [MAG_W-1:0]        q0_s3   [NUM_AXES];
	logic [MAG_W-1:0]        mag_s3  [NUM_AXES];
	logic                    neg_s3  [NUM_AXES];
	logic [MAG_W-1:0]        rem_s3  [NUM_AXES];
	logic [MAG_W-1:0]        quot    [NUM_AXES];
	logic [MEAN_W-1:0]       mean_q  [NUM_AXES];
	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	logic                    out_valid_q;
	logic                    advance;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && !q_status.empty;
	assign out_valid = out_valid_q;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			logic [QD_W-1:0]   qd;
			logic [QD_W-1:0]   diff;
			logic [SUM_W-1:0]  ext;
			ext = {{(SUM_W - CONV_W){head_item.conv[a][CONV_W-1]}}, head_item.conv[a]};
			next_sum[a] = sums_q[a] + signed'(ext);
			qd = QD_W'(q0_s3[a]) * QD_W'(AVG_COUNT);
			diff = QD_W'(mag_s3[a]) - qd;
			rem_s3[a] = diff[MAG_W-1:0];
			if (rem_s3[a] >= MAG_W'(AVG_COUNT)) begin
				quot[a] = q0_s3[a] + 1'b1;
			end else begin
				quot[a] = q0_s3[a];
			end
			means[a] = mean_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				sums_q[a] <= '0;
			end
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (pop) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					sums_q[a] <= head_item.last ? '0 : next_sum[a];
				end
			end
			v_s1        <= pop && head_item.last;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				logic [SUM_W-1:0]  absval;
				logic [PROD_W-1:0] prod;
				logic [MEAN_W-1:0] qn;
				sum_s1[a] <= next_sum[a];
				absval = sum_s1[a][SUM_W-1] ? ({SUM_W{1'b0}} - sum_s1[a]) : sum_s1[a];
				mag_s2[a] <= absval[MAG_W-1:0];
				neg_s2[a] <= sum_s1[a][SUM_W-1];
				prod = PROD_W'(mag_s2[a]) * PROD_W'(RECIP);
				q0_s3[a]  <= prod[RECIP_SHIFT +: MAG_W];
				mag_s3[a] <= mag_s2[a];
				neg_s3[a] <= neg_s2[a];
				qn = MEAN_W'(quot[a]);
				mean_q[a] <= neg_s3[a] ? ({MEAN_W{1'b0}} - qn) : qn;
			end
		end
	end

	`TSSA_ASSERT_NEXT(a_close_starts, clk, arst_n, pop && head_item.last, v_s1, "closing word did not start a mean")
	`TSSA_ASSERT_NEXT(a_sums_cleared, clk, arst_n, pop && head_item.last, (sums_q[0] == '0) && (sums_q[1] == '0) && (sums_q[2] == '0), "sums not cleared after a block")
	`TSSA_ASSERT_SAME(a_recip_bound, clk, arst_n, v_s3, (rem_s3[0] < MAG_W'(2 * AVG_COUNT)) && (rem_s3[1] < MAG_W'(2 * AVG_COUNT)) && (rem_s3[2] < MAG_W'(2 * AVG_COUNT)), "reciprocal estimate off by more than one")

endmodule

[src/triaxial_sample_scale_and_average.sv]
// Channel   Handshake              Word
// input     in_valid / in_stall    x_raw, y_raw, z_raw (16 bits unsigned each)
// output    out_valid / out_stall  x_mean, y_mean, z_mean (15 bits signed each)
//
// One input word is taken per cycle, sustained, as long as the four-entry queue has room.
// The closing word's flag runs from the queue pop through v_s1, v_s2 and v_s3 to out_valid.
// Back pipeline (sum, magnitude, reciprocal multiply, correction): one stage per unstalled cycle.
// Reset clears the sample count, the running sums, the queue and all valid flags.
// A held out_stall freezes the back pipeline while a mean word waits; the input stalls once
// the queue fills.
module triaxial_sample_scale_and_average #(
	parameter int AVG_COUNT = tssa_pkg::AVG_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tssa_pkg::RAW_W-1:0]         x_raw,
	input  logic [tssa_pkg::RAW_W-1:0]         y_raw,
	input  logic [tssa_pkg::RAW_W-1:0]         z_raw,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [tssa_pkg::MEAN_W-1:0] x_mean,
	output logic signed [tssa_pkg::MEAN_W-1:0] y_mean,
	output logic signed [tssa_pkg::MEAN_W-1:0] z_mean
);
	import tssa_pkg::*;

	q_status_t                         q_status;
	item_t                             push_item;
	item_t                             head_item;
	logic                              push;
	logic                              pop;
	logic [NUM_AXES-1:0][MEAN_W-1:0]   means;

	tssa_front #(
		.AVG_COUNT(AVG_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.x_raw    (x_raw),
		.y_raw    (y_raw),
		.z_raw    (z_raw),
		.q_status (q_status),
		.push     (push),
		.push_item(push_item)
	);

	tssa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.q_status (q_status)
	);

	tssa_back #(
		.AVG_COUNT(AVG_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head_item(head_item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.means    (means)
	);

	assign x_mean = signed'(means[0]);
	assign y_mean = signed'(means[1]);
	assign z_mean = signed'(means[2]);

endmodule

[test/tssa_mean_monitor.sv]
module tssa_mean_monitor #(
	parameter int AVG_COUNT = tssa_pkg::AVG_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [tssa_pkg::RAW_W-1:0]         x_raw,
	input  logic [tssa_pkg::RAW_W-1:0]         y_raw,
	input  logic [tssa_pkg::RAW_W-1:0]         z_raw,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [tssa_pkg::MEAN_W-1:0] x_mean,
	input  logic signed [tssa_pkg::MEAN_W-1:0] y_mean,
	input  logic signed [tssa_pkg::MEAN_W-1:0] z_mean,
	output int                                 mismatches,
	output int                                 means_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import tssa_pkg::*;

	typedef logic signed [MEAN_W-1:0] mean_t;

	typedef struct packed {
		mean_t x;
		mean_t y;
		mean_t z;
	} mean_word_t;

	mean_word_t expected_means[$];
	int         axis_total[NUM_AXES] = '{0, 0, 0};
	int         samples_in_block = 0;
	int         errors = 0;

	// A word with an all-ones top nibble is a negative reading of its two's complement.
	function automatic int scaled_reading(input logic [RAW_W-1:0] raw);
		logic [RAW_W-1:0] flipped;
		if (raw[RAW_W-1:LOW_W] == 4'hF) begin
			flipped = 16'h0000 - raw;
			return -4 * int'(flipped[LOW_W-1:0]);
		end
		return 4 * int'(raw[LOW_W-1:0]);
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic compare_axis(input string axis, input mean_t got, input mean_t want);
		if (got !== want) begin
			report($sformatf("%s_mean is %0d, expected %0d", axis, got, want));
		end
	endtask

	always @(posedge clk) begin : watch
		mean_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_means.size() == 0) begin
					report($sformatf("mean word %0d %0d %0d arrived with none expected",
						x_mean, y_mean, z_mean));
				end else begin
					want = expected_means.pop_front();
					compare_axis("x", x_mean, want.x);
					compare_axis("y", y_mean, want.y);
					compare_axis("z", z_mean, want.z);
				end
			end
			if (in_valid && !in_stall) begin
				axis_total[0] += scaled_reading(x_raw);
				axis_total[1] += scaled_reading(y_raw);
				axis_total[2] += scaled_reading(z_raw);
				samples_in_block++;
				if (samples_in_block == AVG_COUNT) begin
					// Integer division truncates toward zero, as the block must.
					want.x = mean_t'(axis_total[0] / AVG_COUNT);
					want.y = mean_t'(axis_total[1] / AVG_COUNT);
					want.z = mean_t'(axis_total[2] / AVG_COUNT);
					expected_means.push_back(want);
					axis_total = '{0, 0, 0};
					samples_in_block = 0;
				end
			end
		end
		mismatches <= errors;
		means_owed <= expected_means.size();
	end

endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tssa_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     out_stall = 1'b0;
	logic [RAW_W-1:0]         x_raw = '0;
	logic [RAW_W-1:0]         y_raw = '0;
	logic [RAW_W-1:0]         z_raw = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic signed [MEAN_W-1:0] x_mean;
	logic signed [MEAN_W-1:0] y_mean;
	logic signed [MEAN_W-1:0] z_mean;
	int                       mismatches;
	int                       means_owed;
	bit                       flood_req = 1'b0;
	int                       idle_cycles = 0;

	always #5 clk = ~clk;

	triaxial_sample_scale_and_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_raw     (x_raw),
		.y_raw     (y_raw),
		.z_raw     (z_raw),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_mean    (x_mean),
		.y_mean    (y_mean),
		.z_mean    (z_mean)
	);

	tssa_mean_monitor mean_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_raw      (x_raw),
		.y_raw      (y_raw),
		.z_raw      (z_raw),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.x_mean     (x_mean),
		.y_mean     (y_mean),
		.z_mean     (z_mean),
		.mismatches (mismatches),
		.means_owed (means_owed)
	);

	function automatic logic [RAW_W-1:0] special_word(input int k);
		case (k)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hF000;
			3: return 16'hF001;
			4: return 16'h0FFF;
			5: return 16'hEFFF;
			6: return 16'h1000;
			7: return 16'h8000;
			8: return 16'h7FFF;
			default: return 16'hF800;
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] sample_word();
		case ($urandom_range(0, 5))
			0: return special_word($urandom_range(0, 9));
			1: return {4'hF, 12'($urandom)};
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic offer(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
		input logic [RAW_W-1:0] z);
		@(negedge clk);
		in_valid <= 1'b1;
		x_raw <= x;
		y_raw <= y;
		z_raw <= z;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic rest(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			x_raw <= RAW_W'($urandom);
			y_raw <= RAW_W'($urandom);
			z_raw <= RAW_W'($urandom);
		end
	endtask

	task automatic drain();
		rest(1);
		while (means_owed != 0) @(negedge clk);
	endtask

	initial begin : receiver
		int          hold_left;
		int          span;
		bit          hold_seen;
		stall_mode_t mode;
		hold_left = 0;
		span = 0;
		hold_seen = 1'b0;
		mode = STALL_NONE;
		forever begin
			@(negedge clk);
			if (flood_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					span = $urandom_range(5, 60);
				end
				span--;
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HALF: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** triaxial_sample_scale_and_average: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int  sent;
		int  burst;
		bit  paused;
		sent = 0;
		paused = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The second block gives y and z small negative sums whose means must truncate toward zero.
		for (int i = 0; i < 20; i++) begin
			if (i < 10) begin
				offer(16'h0FFF, 16'hF001, special_word(i));
			end else begin
				offer(special_word(19 - i), (i == 10) ? 16'hFFF5 : 16'h0000,
					(i == 10) ? 16'hFFFF : 16'hF000);
			end
		end
		drain();

		// The receiver holds off while words keep coming, so the block fills and stalls.
		flood_req <= 1'b1;
		repeat (120) offer(sample_word(), sample_word(), sample_word());
		drain();

		while (sent < 460) begin
			burst = $urandom_range(1, 25);
			repeat (burst) offer(sample_word(), sample_word(), sample_word());
			sent += burst;
			if (!paused && sent > 230) begin
				paused = 1'b1;
				drain();
			end else if ($urandom_range(0, 3) != 0) begin
				rest($urandom_range(1, 6));
			end
		end
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && means_owed == 0) begin
			$display("** triaxial_sample_scale_and_average: PASSED **");
		end else begin
			$display("** triaxial_sample_scale_and_average: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/tssa_pkg.sv
src/tssa_front.sv
src/tssa_queue.sv
src/tssa_back.sv
src/triaxial_sample_scale_and_average.sv
test/tssa_mean_monitor.sv
test/testbench.sv
